FILE: hdl/pixel_raster_op_unit_defines.svh
// ----------------------------------------------------------------------------
// Pixel raster op unit: assertion macros
// Shared assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PIXEL_RASTER_OP_UNIT_DEFINES_SVH
`define PIXEL_RASTER_OP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PXROP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pixel raster op unit: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PXROP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pixel raster op unit: next-cycle check failed");

`else

`define PXROP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PXROP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/pxrop_pkg.sv
// ----------------------------------------------------------------------------
// Pixel raster op unit: package
// Mode and register codes, canvas position tables, shade and modulo helpers.
// ----------------------------------------------------------------------------
package pxrop_pkg;

    localparam int LINE_PITCH   = 256;
    localparam int SHADE_STEPS  = 8;
    localparam int LEVEL_MAX    = 15;

    // Dividend width of the grid remainder: row can reach 255.
    localparam int DIV_W = 9;

    // Mode codes
    localparam logic [3:0] MODE_COPY          = 4'd0;
    localparam logic [3:0] MODE_DARKEN        = 4'd1;
    localparam logic [3:0] MODE_SOLID         = 4'd2;
    localparam logic [3:0] MODE_SOLID_GRID    = 4'd3;
    localparam logic [3:0] MODE_INVERT_DST    = 4'd4;
    localparam logic [3:0] MODE_INVERT_SRC    = 4'd5;
    localparam logic [3:0] MODE_INVERT_GRID   = 4'd6;
    localparam logic [3:0] MODE_COPY_GRID     = 4'd7;
    localparam logic [3:0] MODE_COPY_CHECKER  = 4'd8;
    localparam logic [3:0] MODE_SOLID_CHECKER = 4'd9;
    localparam logic [3:0] MODE_LIGHTEN       = 4'd10;
    localparam logic [3:0] MODE_TINT          = 4'd11;

    // Tint palette codes
    localparam logic [1:0] TINT_DARKEN  = 2'd0;
    localparam logic [1:0] TINT_RED     = 2'd1;
    localparam logic [1:0] TINT_LIGHTEN = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_PARAM_A     = 2'd1;
    localparam logic [1:0] CFG_PARAM_B     = 2'd2;
    localparam logic [1:0] CFG_TINT_SELECT = 2'd3;

    typedef enum logic [1:0] {
        KIND_DARK  = 2'd0,
        KIND_RED   = 2'd1,
        KIND_LIGHT = 2'd2
    } t_kind;

    typedef logic [7:0] t_byte_tbl [256];

    // Pixel item as it moves down the pipeline.
    typedef struct packed {
        logic [DIV_W-1:0] x;
        logic [DIV_W-1:0] y;
        logic [7:0]       rem_x;
        logic [7:0]       rem_y;
        logic             par;
        logic [7:0]       shade;
        logic [7:0]       src;
        logic [7:0]       dst;
    } t_pix;

    function automatic t_byte_tbl build_col_tbl();
        t_byte_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = 8'(i % LINE_PITCH);
        end
        return tbl;
    endfunction

    function automatic t_byte_tbl build_row_tbl();
        t_byte_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = 8'(i / LINE_PITCH);
        end
        return tbl;
    endfunction

    // Column of a raw x, and the rows it wraps forward.
    localparam t_byte_tbl COL_TBL = build_col_tbl();
    localparam t_byte_tbl ROW_TBL = build_row_tbl();

    // Three restoring remainder steps, most significant bit first.
    function automatic logic [7:0] mod_steps3(input logic [7:0] rem,
                                              input logic [2:0] bits,
                                              input logic [7:0] period);
        logic [8:0] t;
        logic [7:0] r;
        r = rem;
        for (int i = 2; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, period}) begin
                t = t - {1'b0, period};
            end
            r = t[7:0];
        end
        return r;
    endfunction

    // Dither amount: half the saturated level, plus its odd bit off parity.
    function automatic logic [2:0] dither_amount(input logic [7:0] level_in,
                                                 input logic       par);
        logic [3:0] level;
        logic [3:0] n;
        level = (level_in > 8'(LEVEL_MAX)) ? 4'(LEVEL_MAX) : level_in[3:0];
        n     = {1'b0, level[3:1]} + (par ? 4'd0 : {3'b000, level[0]});
        return (n > 4'(SHADE_STEPS - 1)) ? 3'(SHADE_STEPS - 1) : n[2:0];
    endfunction

    // Saturating per-channel step; blue moves at half rate.
    function automatic logic [7:0] shade(input logic [7:0] color,
                                         input logic [2:0] n,
                                         input t_kind      kind);
        logic [2:0] r, g, r_up, g_up, r_dn, g_dn;
        logic [1:0] b, nb, b_up, b_dn;
        logic [3:0] r_sum, g_sum;
        logic [2:0] b_sum;
        r     = color[7:5];
        g     = color[4:2];
        b     = color[1:0];
        nb    = n[2:1];
        r_sum = {1'b0, r} + {1'b0, n};
        g_sum = {1'b0, g} + {1'b0, n};
        b_sum = {1'b0, b} + {1'b0, nb};
        r_up  = r_sum[3] ? 3'd7 : r_sum[2:0];
        g_up  = g_sum[3] ? 3'd7 : g_sum[2:0];
        b_up  = b_sum[2] ? 2'd3 : b_sum[1:0];
        r_dn  = (r > n) ? r - n : 3'd0;
        g_dn  = (g > n) ? g - n : 3'd0;
        b_dn  = (b > nb) ? b - nb : 2'd0;
        case (kind)
            KIND_LIGHT: return {r_up, g_up, b_up};
            KIND_RED:   return {r_up, g_dn, b_dn};
            default:    return {r_dn, g_dn, b_dn};
        endcase
    endfunction

endpackage

FILE: hdl/pixel_raster_op_unit.sv
// ----------------------------------------------------------------------------
// Pixel raster op unit
// Per-pixel write stage for an RGB332 frame buffer: copy, solid, invert,
// grid-skip, checkerboard and dithered shade modes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------
//  pixel in  input      i_valid / o_stall     i_pixel_x, i_pixel_y,
//                                             i_src_color, i_dst_color
//  result    output     o_valid / i_stall     o_write_enable, o_new_color
//  config    input      i_cfg_we              i_cfg_index, i_cfg_data
//
//  One pixel per clock sustained while i_stall is low; a result passes every
//  work stage and then the output register before it turns valid.
//  The depth is set by the grid remainder, a restoring
//  modulo by the period that runs three bits per stage over stages two to four.
//  Reset (i_rst_n low at a clock edge) empties the pipeline and clears the
//  registers to copy mode with zero parameters.
//  A stalled result holds in the output register; bubbles ahead of it still
//  fill, so the input keeps taking pixels until every stage is occupied.
//
`include "pixel_raster_op_unit_defines.svh"

module pixel_raster_op_unit
    import pxrop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // pixel in
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic [7:0] i_src_color,
    input  logic [7:0] i_dst_color,
    // result
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_write_enable,
    output logic [7:0] o_new_color,
    // config
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int NUM_STG = 5;   // four work stages and the output register

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [3:0] r_mode;
    logic [7:0] r_param_a;
    logic [7:0] r_param_b;
    logic [1:0] r_tint_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_COPY;
            r_param_a     <= 8'd0;
            r_param_b     <= 8'd0;
            r_tint_select <= TINT_DARKEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[3:0];
                CFG_PARAM_A:     r_param_a     <= i_cfg_data;
                CFG_PARAM_B:     r_param_b     <= i_cfg_data;
                CFG_TINT_SELECT: r_tint_select <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // A grid period of zero skips every pixel, same as a period of one.
    logic [7:0] w_period;
    assign w_period = (r_param_a == 8'd0) ? 8'd1 : r_param_a;

    // Palette for the shade modes.
    t_kind w_kind;
    always_comb begin
        w_kind = KIND_DARK;
        if (r_mode == MODE_LIGHTEN) begin
            w_kind = KIND_LIGHT;
        end else if (r_mode == MODE_TINT) begin
            if (r_tint_select == TINT_RED) begin
                w_kind = KIND_RED;
            end else if (r_tint_select == TINT_LIGHTEN) begin
                w_kind = KIND_LIGHT;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow: a stage advances when it is empty or the next one moves
    // ------------------------------------------------------------------------
    logic [NUM_STG:1] r_vld;
    logic [NUM_STG:1] w_en;

    always_comb begin
        w_en[NUM_STG] = !r_vld[NUM_STG] || !i_stall;
        for (int k = NUM_STG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[1];
    assign o_valid = r_vld[NUM_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Work stages
    //   1: wrap the column onto the canvas, take checker parity
    //   2: shade the destination; remainder bits 8..6
    //   3: remainder bits 5..3
    //   4: remainder bits 2..0
    // ------------------------------------------------------------------------
    t_pix r_stg [1:NUM_STG-1];
    t_pix n_stg [1:NUM_STG-1];

    always_comb begin
        logic [7:0] col;
        logic [8:0] row;
        col = COL_TBL[i_pixel_x];
        row = {1'b0, i_pixel_y} + {1'b0, ROW_TBL[i_pixel_x]};

        n_stg[1]       = '0;
        n_stg[1].x     = {1'b0, col};
        n_stg[1].y     = row;
        n_stg[1].par   = (col[0] == row[0]);
        n_stg[1].src   = i_src_color;
        n_stg[1].dst   = i_dst_color;

        // Advance both remainders by three dividend bits per stage.
        for (int k = 2; k <= NUM_STG - 1; k++) begin
            n_stg[k]       = r_stg[k-1];
            n_stg[k].rem_x = mod_steps3(r_stg[k-1].rem_x,
                                        r_stg[k-1].x[(DIV_W-1-3*(k-2)) -: 3], w_period);
            n_stg[k].rem_y = mod_steps3(r_stg[k-1].rem_y,
                                        r_stg[k-1].y[(DIV_W-1-3*(k-2)) -: 3], w_period);
        end

        n_stg[2].shade = shade(r_stg[1].dst,
                               dither_amount(r_param_a, r_stg[1].par), w_kind);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= NUM_STG - 1; k++) begin
            if (w_en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: mode select into the result register
    // ------------------------------------------------------------------------
    logic       r_out_we;
    logic [7:0] r_out_color;
    logic       n_out_we;
    logic [7:0] n_out_color;
    logic       w_on_grid;
    t_pix       w_last;

    assign w_last    = r_stg[NUM_STG-1];
    assign w_on_grid = (w_last.rem_x == 8'd0) || (w_last.rem_y == 8'd0);

    always_comb begin
        n_out_we    = 1'b1;
        n_out_color = w_last.dst;
        unique case (r_mode) inside
            MODE_DARKEN, MODE_LIGHTEN, MODE_TINT: begin
                n_out_color = w_last.shade;
            end
            MODE_SOLID: begin
                n_out_color = r_param_a;
            end
            MODE_SOLID_GRID: begin
                if (w_on_grid) n_out_we = 1'b0;
                else           n_out_color = r_param_b;
            end
            MODE_INVERT_DST: begin
                n_out_color = ~w_last.dst;
            end
            MODE_INVERT_SRC: begin
                n_out_color = ~w_last.src;
            end
            MODE_INVERT_GRID: begin
                if (w_on_grid) n_out_we = 1'b0;
                else           n_out_color = ~w_last.dst;
            end
            MODE_COPY_GRID: begin
                if (w_on_grid) n_out_we = 1'b0;
                else           n_out_color = w_last.src;
            end
            MODE_COPY_CHECKER: begin
                if (w_last.par) n_out_color = w_last.src;
                else            n_out_we = 1'b0;
            end
            MODE_SOLID_CHECKER: begin
                if (w_last.par) n_out_color = r_param_b;
                else            n_out_we = 1'b0;
            end
            // copy, and the unused codes
            default: begin
                n_out_color = w_last.src;
            end
        endcase
    end

    // Hold the result while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (w_en[NUM_STG]) begin
            r_out_we    <= n_out_we;
            r_out_color <= n_out_color;
        end
    end

    assign o_write_enable = r_out_we;
    assign o_new_color    = r_out_color;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PXROP_ASSERT_IMPLY(a_stall_only_when_sink_stalls, i_clk, i_rst_n, o_stall, i_stall)
    `PXROP_ASSERT_NEXT(a_transfer_fills_first_stage, i_clk, i_rst_n, i_valid && !o_stall, r_vld[1])
    `PXROP_ASSERT_NEXT(a_last_stage_reaches_output, i_clk, i_rst_n, r_vld[NUM_STG-1] && w_en[NUM_STG], r_vld[NUM_STG])

endmodule
